@@ rtl/core/sle_pkg.sv @@
// Shared types, character codes and echo tables for the serial line editor.
// No dependencies; sle_out_stage, serial_line_editor and sle_checker import this package.
`default_nettype none

package sle_pkg;

    localparam int LINE_SIZE_DEF = 32;

    // Character codes the editor reacts to
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_DC2  = 8'h12;   // ctrl-R, retype
    localparam logic [7:0] CH_NAK  = 8'h15;   // ctrl-U, kill line
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_DEL  = 8'h7f;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO,
        ST_DUMP,
        ST_TERM
    } state_t;

    typedef enum logic [1:0] {
        ECHO_CHAR,
        ECHO_RUB,
        ECHO_CRLF,
        ECHO_KILL
    } echo_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic       line_done;
        logic       last;
    } sle_res_t;

    // Position of the final byte of each echo string
    function automatic logic [2:0] echo_last(echo_t sel);
        logic [2:0] p;
        unique case (sel)
            ECHO_CHAR: p = 3'd0;
            ECHO_RUB:  p = 3'd2;
            ECHO_CRLF: p = 3'd1;
            ECHO_KILL: p = 3'd4;
            default:   p = 3'd0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] echo_byte(echo_t sel, logic [2:0] pos, logic [7:0] ch);
        logic [7:0] b;
        unique case (sel)
            ECHO_CHAR: b = ch;
            ECHO_RUB:  b = (pos == 3'd1) ? CH_SP : CH_BS;
            ECHO_CRLF: b = (pos == 3'd0) ? CH_CR : CH_LF;
            ECHO_KILL: b = (pos < 3'd3) ? CH_X : ((pos == 3'd3) ? CH_CR : CH_LF);
            default:   b = ch;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sle_in_if.sv @@
// Input channel of the serial line editor: one received character per beat.
// No dependencies.
`default_nettype none

interface sle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sle_out_if.sv @@
// Output channel of the serial line editor: one echo or line byte per beat.
// No dependencies.
`default_nettype none

interface sle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       kind;
    logic       line_done;
    logic       last;

    modport source (output valid, output out_byte, output kind, output line_done,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input line_done,
                    input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sle_out_stage.sv @@
// Output register of the serial line editor; decouples the sequencer from
// downstream stalls. Depends on sle_pkg and sle_out_if.
`default_nettype none

module sle_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire sle_pkg::sle_res_t push_data,
    output logic                  push_ready,
    sle_out_if.source             out_ch
);
    import sle_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    sle_res_t data_reg;

    assign push_ready = !valid_reg || out_ch.ready;
    assign valid_next = push_ready ? push_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
        end
    end

    assign out_ch.valid     = valid_reg;
    assign out_ch.out_byte  = data_reg.out_byte;
    assign out_ch.kind      = data_reg.kind;
    assign out_ch.line_done = data_reg.line_done;
    assign out_ch.last      = data_reg.last;

endmodule

`default_nettype wire

@@ rtl/core/serial_line_editor.sv @@
// Serial line editor: an accepted character passes the sequencer state register
// and then the output register before its first result beat is on the output.
// One result beat per cycle while downstream is ready; the input stays closed
// until the last result of a character is pushed, so no new character is taken
// before the last is through. The line store is read one entry per cycle.
// Reset clears the character count and empties the output; store contents stay.
`default_nettype none

module serial_line_editor #(
    parameter int LINE_SIZE = sle_pkg::LINE_SIZE_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sle_in_if.sink    in_ch,
    sle_out_if.source out_ch
);
    import sle_pkg::*;

    localparam int DEPTH = LINE_SIZE - 1;
    localparam int CNT_W = $clog2(LINE_SIZE);
    localparam int IDX_W = $clog2(DEPTH);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]         ch_reg, ch_next;
    echo_t              sel_reg, sel_next;
    logic [2:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic               dkind_reg, dkind_next;
    logic               term_reg, term_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [7:0]         rd_data_reg;
    logic [7:0]         mem [DEPTH];

    logic               accept;
    logic               wr_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               push_valid;
    logic               push_ready;
    sle_res_t           push_data;
    logic               echo_end;
    logic               dump_end;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign echo_end    = (pos_reg == echo_last(sel_reg));
    assign dump_end    = ((idx_reg + CNT_W'(1)) == len_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        sel_next   = sel_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        dkind_next = dkind_reg;
        term_next  = term_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        rd_addr    = '0;
        push_valid = 1'b0;
        push_data  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ch_next    = in_ch.rx_char;
                    pos_next   = '0;
                    idx_next   = '0;
                    len_next   = '0;
                    dkind_next = 1'b0;
                    term_next  = 1'b0;
                    unique case (in_ch.rx_char) inside
                        CH_NUL, CH_LF:
                        begin
                        end
                        CH_DEL, CH_BS:
                        begin
                            if (cnt_reg != '0)
                            begin
                                sel_next   = ECHO_RUB;
                                cnt_next   = cnt_reg - CNT_W'(1);
                                state_next = ST_ECHO;
                            end
                        end
                        CH_DC2:
                        begin
                            sel_next   = ECHO_CRLF;
                            len_next   = cnt_reg;
                            state_next = ST_ECHO;
                        end
                        CH_NAK:
                        begin
                            sel_next   = ECHO_KILL;
                            cnt_next   = '0;
                            state_next = ST_ECHO;
                        end
                        CH_CR, CH_SEMI:
                        begin
                            sel_next   = ECHO_CRLF;
                            len_next   = cnt_reg;
                            dkind_next = 1'b1;
                            term_next  = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_ECHO;
                        end
                        default:
                        begin
                            wr_en      = 1'b1;
                            sel_next   = ECHO_CHAR;
                            state_next = ST_ECHO;
                            if ((cnt_reg + CNT_W'(1)) == CNT_W'(DEPTH))
                            begin
                                // buffer full: flush without CR LF
                                len_next   = CNT_W'(DEPTH);
                                dkind_next = 1'b1;
                                term_next  = 1'b1;
                                cnt_next   = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                    endcase
                end
            end
            ST_ECHO:
            begin
                // rd_addr stays 0 here, so entry 0 is ready on entering ST_DUMP
                push_valid         = 1'b1;
                push_data.out_byte = echo_byte(sel_reg, pos_reg, ch_reg);
                push_data.last     = echo_end && (len_reg == '0) && !term_reg;
                if (push_ready)
                begin
                    if (echo_end)
                    begin
                        if (len_reg != '0)
                            state_next = ST_DUMP;
                        else if (term_reg)
                            state_next = ST_TERM;
                        else
                            state_next = ST_IDLE;
                    end
                    else
                    begin
                        pos_next = pos_reg + 3'd1;
                    end
                end
            end
            ST_DUMP:
            begin
                push_valid         = 1'b1;
                push_data.out_byte = rd_data_reg;
                push_data.kind     = dkind_reg;
                push_data.last     = dump_end && !term_reg;
                rd_addr            = idx_reg[IDX_W-1:0];
                if (push_ready)
                begin
                    if (dump_end)
                    begin
                        state_next = term_reg ? ST_TERM : ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                        rd_addr  = idx_next[IDX_W-1:0];
                    end
                end
            end
            ST_TERM:
            begin
                push_valid          = 1'b1;
                push_data.kind      = 1'b1;
                push_data.line_done = 1'b1;
                push_data.last      = 1'b1;
                if (push_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg    <= ch_next;
        sel_reg   <= sel_next;
        pos_reg   <= pos_next;
        len_reg   <= len_next;
        dkind_reg <= dkind_next;
        term_reg  <= term_next;
        idx_reg   <= idx_next;
    end

    // Line store: written on an accepted character that is stored, read every cycle.
    // A write always lands before any dump that reads it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cnt_reg[IDX_W-1:0]] <= in_ch.rx_char;
        rd_data_reg <= mem[rd_addr];
    end

    sle_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

@@ rtl/core/sle_checker.sv @@
// Port-level checks for serial_line_editor, bound to the top level.
// Depends on sle_pkg for the character codes.
`default_nettype none

module sle_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] rx_char,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       kind,
    input wire logic       line_done,
    input wire logic       last
);
    import sle_pkg::*;

    // a terminator beat always closes the item and carries a zero byte
    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> kind && last && (out_byte == 8'h00))
        else $error("terminator beat malformed");

    // input opens only once the final result of the previous item is queued
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> last)
        else $error("input ready while an item still has results pending");

    // any character but NUL, LF, BS and DEL always produces output, so the input closes
    a_busy_after_char: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (rx_char != CH_NUL) && (rx_char != CH_LF) &&
        (rx_char != CH_BS) && (rx_char != CH_DEL) |=> !in_ready)
        else $error("input stayed ready after a character with results");

    // NUL produces nothing
    a_nul_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (rx_char == CH_NUL) && !out_valid |=> !out_valid)
        else $error("result produced for NUL");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind) &&
        $stable(line_done) && $stable(last))
        else $error("stalled output beat changed");

endmodule

bind serial_line_editor sle_checker u_sle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .rx_char   (in_ch.rx_char),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .kind      (out_ch.kind),
    .line_done (out_ch.line_done),
    .last      (out_ch.last)
);

`default_nettype wire
